@@ rtl/hsp_pkg.sv @@
// shared types and constants for the http start line and header parser
package hsp_pkg;

   // parser position within the message
   typedef enum logic [4:0] {
      PH_START  = 5'd0,
      PH_METHOD = 5'd1,
      PH_URI    = 5'd2,
      PH_LIT    = 5'd3,
      PH_MAJOR  = 5'd4,
      PH_MINOR  = 5'd5,
      PH_REQLF  = 5'd6,
      PH_STATUS = 5'd7,
      PH_REASON = 5'd8,
      PH_HLINE  = 5'd9,
      PH_ENDLF  = 5'd10,
      PH_HNAME  = 5'd11,
      PH_HWS    = 5'd12,
      PH_VSKIP  = 5'd13,
      PH_VALUE  = 5'd14,
      PH_VCR    = 5'd15,
      PH_VLF    = 5'd16
   } phase_type;

   // field tag attached to each byte
   typedef enum logic [3:0] {
      K_SYN    = 4'd0,
      K_METHOD = 4'd1,
      K_URI    = 4'd2,
      K_MAJOR  = 4'd3,
      K_MINOR  = 4'd4,
      K_SDIGIT = 4'd5,
      K_REASON = 4'd6,
      K_NAME   = 4'd7,
      K_VALUE  = 4'd8,
      K_SDONE  = 4'd9,
      K_DONE   = 4'd10,
      K_ERR    = 4'd11
   } kind_type;

   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 10;

   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [STATUS_W-1:0] status_type;

   // one result item
   typedef struct packed {
      kind_type   kind;
      byte_type   data_char;
      status_type status_value;
      logic       header_end;
      logic       cr_before;
   } rsp_payload_type;

endpackage

@@ rtl/hsp_if.sv @@
// valid/ready channel interfaces for parser input bytes and tagged results
interface hsp_req_if;
   logic              valid;
   logic              ready;
   hsp_pkg::byte_type data_byte;
   logic              at_end;

   modport source (output valid, data_byte, at_end, input ready);
   modport sink (input valid, data_byte, at_end, output ready);
endinterface

interface hsp_rsp_if;
   logic                valid;
   logic                ready;
   hsp_pkg::kind_type   kind;
   hsp_pkg::byte_type   data_char;
   hsp_pkg::status_type status_value;
   logic                header_end;
   logic                cr_before;

   modport source (output valid, kind, data_char, status_value, header_end, cr_before,
                   input ready);
   modport sink (input valid, kind, data_char, status_value, header_end, cr_before,
                 output ready);
endinterface

@@ rtl/hsp_core.sv @@
// parser state registers and the per-byte classification and update logic
module hsp_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  logic                     response_mode,
   input  hsp_pkg::byte_type        data_byte,
   input  logic                     at_end,
   output hsp_pkg::rsp_payload_type result
);

   localparam hsp_pkg::byte_type CH_CR    = 8'h0D;
   localparam hsp_pkg::byte_type CH_LF    = 8'h0A;
   localparam hsp_pkg::byte_type CH_SP    = 8'h20;
   localparam hsp_pkg::byte_type CH_TAB   = 8'h09;
   localparam hsp_pkg::byte_type CH_COLON = 8'h3A;
   localparam hsp_pkg::byte_type CH_DOT   = 8'h2E;
   localparam hsp_pkg::byte_type CH_ZERO  = 8'h30;
   localparam hsp_pkg::byte_type CH_NINE  = 8'h39;
   localparam hsp_pkg::byte_type CH_DEL   = 8'd127;
   localparam hsp_pkg::byte_type CTL_MAX  = 8'd31;
   localparam logic [2:0]        LIT_LAST = 3'd4;
   localparam logic [1:0]        DIGITS   = 2'd3;

   // control characters
   function automatic logic is_ctl(input hsp_pkg::byte_type c);
      return (c <= CTL_MAX) || (c == CH_DEL);
   endfunction

   function automatic logic is_ws(input hsp_pkg::byte_type c);
      return (c == CH_SP) || (c == CH_TAB);
   endfunction

   function automatic logic is_decimal(input hsp_pkg::byte_type c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // token characters: printable ascii minus separators
   function automatic logic is_token(input hsp_pkg::byte_type c);
      logic ok;
      ok = !c[7] && !is_ctl(c);
      case (c)
         8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
         8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: ok = 1'b0;
         default: ok = ok;
      endcase
      return ok;
   endfunction

   // expected characters of the version literal
   function automatic hsp_pkg::byte_type lit_char(input logic [2:0] pos);
      hsp_pkg::byte_type ch;
      case (pos)
         3'd0:    ch = 8'h48;
         3'd1:    ch = 8'h54;
         3'd2:    ch = 8'h54;
         3'd3:    ch = 8'h50;
         3'd4:    ch = 8'h2F;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   hsp_pkg::phase_type  phase_ff, phase_in;
   logic [2:0]          literal_pos_ff, literal_pos_in;
   logic [1:0]          digit_count_ff, digit_count_in;
   hsp_pkg::status_type status_acc_ff, status_acc_in;
   logic                field_seen_ff, field_seen_in;
   logic                pending_cr_ff, pending_cr_in;

   hsp_pkg::kind_type   kind;
   hsp_pkg::status_type status_out;
   logic                hend;
   logic                crb;
   logic                finished;
   logic [13:0]         acc_next;
   hsp_pkg::byte_type   c;

   assign c = data_byte;

   // status accumulator times ten plus the new digit
   assign acc_next = 14'(status_acc_ff) * 14'd10 + 14'(c - CH_ZERO);

   // next state and result for one byte
   always_comb begin
      phase_in       = phase_ff;
      literal_pos_in = literal_pos_ff;
      digit_count_in = digit_count_ff;
      status_acc_in  = status_acc_ff;
      field_seen_in  = field_seen_ff;
      pending_cr_in  = pending_cr_ff;
      kind           = hsp_pkg::K_ERR;
      status_out     = '0;
      hend           = 1'b0;
      crb            = 1'b0;
      finished       = 1'b0;

      if (at_end) begin
         finished = 1'b1;
      end else begin
         // first byte of a message picks the start line form
         if (phase_in == hsp_pkg::PH_START) begin
            phase_in = response_mode ? hsp_pkg::PH_LIT : hsp_pkg::PH_METHOD;
         end
         // after a value line: whitespace folds, anything else opens a new line
         if (phase_in == hsp_pkg::PH_VLF) begin
            if (is_ws(c)) begin
               phase_in = hsp_pkg::PH_VSKIP;
               kind     = hsp_pkg::K_SYN;
               finished = 1'b1;
            end else begin
               hend     = 1'b1;
               phase_in = hsp_pkg::PH_HLINE;
            end
         end
         // held carriage return in the reason phrase
         if (!finished && phase_in == hsp_pkg::PH_REASON && pending_cr_in) begin
            pending_cr_in = 1'b0;
            if (c == CH_LF) begin
               phase_in      = hsp_pkg::PH_HLINE;
               field_seen_in = 1'b0;
               kind          = hsp_pkg::K_SYN;
               finished      = 1'b1;
            end else begin
               crb = 1'b1;
            end
         end
         if (!finished) begin
            case (phase_in)
               hsp_pkg::PH_METHOD: begin
                  if (is_token(c)) begin
                     kind = hsp_pkg::K_METHOD; field_seen_in = 1'b1;
                  end else if (c == CH_SP && field_seen_in) begin
                     kind = hsp_pkg::K_SYN; phase_in = hsp_pkg::PH_URI; field_seen_in = 1'b0;
                  end
               end
               hsp_pkg::PH_URI: begin
                  if (!is_ctl(c) && c != CH_SP) begin
                     kind = hsp_pkg::K_URI; field_seen_in = 1'b1;
                  end else if (c == CH_SP && field_seen_in) begin
                     kind = hsp_pkg::K_SYN; phase_in = hsp_pkg::PH_LIT;
                     field_seen_in = 1'b0; literal_pos_in = '0;
                  end
               end
               hsp_pkg::PH_LIT: begin
                  if (literal_pos_in <= LIT_LAST && c == lit_char(literal_pos_in)) begin
                     kind = hsp_pkg::K_SYN;
                     if (literal_pos_in == LIT_LAST) begin
                        phase_in = hsp_pkg::PH_MAJOR; field_seen_in = 1'b0;
                        literal_pos_in = '0;
                     end else begin
                        literal_pos_in = literal_pos_in + 3'd1;
                     end
                  end
               end
               hsp_pkg::PH_MAJOR: begin
                  if (is_decimal(c)) begin
                     kind = hsp_pkg::K_MAJOR; field_seen_in = 1'b1;
                  end else if (c == CH_DOT && field_seen_in) begin
                     kind = hsp_pkg::K_SYN; phase_in = hsp_pkg::PH_MINOR; field_seen_in = 1'b0;
                  end
               end
               hsp_pkg::PH_MINOR: begin
                  if (is_decimal(c)) begin
                     kind = hsp_pkg::K_MINOR; field_seen_in = 1'b1;
                  end else if (field_seen_in && !response_mode && c == CH_CR) begin
                     kind = hsp_pkg::K_SYN; phase_in = hsp_pkg::PH_REQLF; field_seen_in = 1'b0;
                  end else if (field_seen_in && response_mode && c == CH_SP) begin
                     kind = hsp_pkg::K_SYN; phase_in = hsp_pkg::PH_STATUS; field_seen_in = 1'b0;
                     digit_count_in = '0; status_acc_in = '0;
                  end
               end
               hsp_pkg::PH_REQLF: begin
                  if (c == CH_LF) begin
                     kind = hsp_pkg::K_SYN; phase_in = hsp_pkg::PH_HLINE; field_seen_in = 1'b0;
                  end
               end
               hsp_pkg::PH_STATUS: begin
                  if (is_decimal(c)) begin
                     if (digit_count_in < DIGITS) begin
                        kind           = hsp_pkg::K_SDIGIT;
                        status_acc_in  = acc_next[9:0];
                        digit_count_in = digit_count_in + 2'd1;
                     end
                  end else if (c == CH_SP && digit_count_in == DIGITS) begin
                     kind = hsp_pkg::K_SDONE; status_out = status_acc_in;
                     phase_in = hsp_pkg::PH_REASON; field_seen_in = 1'b0;
                  end
               end
               hsp_pkg::PH_REASON: begin
                  if (c == CH_CR) begin
                     kind = hsp_pkg::K_SYN; pending_cr_in = 1'b1;
                  end else begin
                     kind = hsp_pkg::K_REASON;
                  end
               end
               hsp_pkg::PH_HLINE: begin
                  if (c == CH_CR) begin
                     kind = hsp_pkg::K_SYN; phase_in = hsp_pkg::PH_ENDLF; field_seen_in = 1'b0;
                  end else if (is_token(c)) begin
                     kind = hsp_pkg::K_NAME; phase_in = hsp_pkg::PH_HNAME; field_seen_in = 1'b0;
                  end
               end
               hsp_pkg::PH_ENDLF: begin
                  if (c == CH_LF) begin
                     kind = hsp_pkg::K_DONE;
                  end
               end
               hsp_pkg::PH_HNAME: begin
                  if (c == CH_COLON) begin
                     kind = hsp_pkg::K_SYN; phase_in = hsp_pkg::PH_HWS; field_seen_in = 1'b0;
                  end else if (is_token(c)) begin
                     kind = hsp_pkg::K_NAME;
                  end
               end
               hsp_pkg::PH_HWS: begin
                  if (is_ws(c)) begin
                     kind = hsp_pkg::K_SYN; phase_in = hsp_pkg::PH_VSKIP; field_seen_in = 1'b0;
                  end
               end
               hsp_pkg::PH_VSKIP: begin
                  if (is_ws(c)) begin
                     kind = hsp_pkg::K_SYN;
                  end else if (c == CH_CR) begin
                     kind = hsp_pkg::K_SYN; phase_in = hsp_pkg::PH_VCR; field_seen_in = 1'b0;
                  end else if (!is_ctl(c)) begin
                     kind = hsp_pkg::K_VALUE; phase_in = hsp_pkg::PH_VALUE; field_seen_in = 1'b0;
                  end
               end
               hsp_pkg::PH_VALUE: begin
                  if (c == CH_CR) begin
                     kind = hsp_pkg::K_SYN; phase_in = hsp_pkg::PH_VCR; field_seen_in = 1'b0;
                  end else if (!is_ctl(c)) begin
                     kind = hsp_pkg::K_VALUE;
                  end
               end
               hsp_pkg::PH_VCR: begin
                  if (c == CH_LF) begin
                     kind = hsp_pkg::K_SYN; phase_in = hsp_pkg::PH_VLF; field_seen_in = 1'b0;
                  end
               end
               default: begin
                  kind = hsp_pkg::K_ERR;
               end
            endcase
         end
      end

      // error, early end or completed message: back to the first line
      if (kind == hsp_pkg::K_ERR || kind == hsp_pkg::K_DONE) begin
         phase_in       = hsp_pkg::PH_START;
         literal_pos_in = '0;
         digit_count_in = '0;
         status_acc_in  = '0;
         field_seen_in  = 1'b0;
         pending_cr_in  = 1'b0;
      end
   end

   // result fields
   always_comb begin
      result.kind         = kind;
      result.data_char    = at_end ? '0 : c;
      result.status_value = status_out;
      result.header_end   = hend;
      result.cr_before    = crb;
   end

   // parser state, updated once per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= hsp_pkg::PH_START;
         literal_pos_ff <= '0;
         digit_count_ff <= '0;
         status_acc_ff  <= '0;
         field_seen_ff  <= 1'b0;
         pending_cr_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         literal_pos_ff <= literal_pos_in;
         digit_count_ff <= digit_count_in;
         status_acc_ff  <= status_acc_in;
         field_seen_ff  <= field_seen_in;
         pending_cr_ff  <= pending_cr_in;
      end
   end

   // an error or a completed message leaves the parser at the first line
   a_restart: assert property (@(posedge clock) disable iff (reset)
      step_en && (result.kind == hsp_pkg::K_ERR || result.kind == hsp_pkg::K_DONE)
      |=> phase_ff == hsp_pkg::PH_START && !pending_cr_ff && digit_count_ff == '0)
      else $error("parser did not restart after error or completion");

   // a held carriage return only lives inside the reason phrase
   a_cr_phase: assert property (@(posedge clock) disable iff (reset)
      pending_cr_ff |-> phase_ff == hsp_pkg::PH_REASON)
      else $error("held carriage return outside reason phrase");

   // status value is only reported with the status-done tag
   a_status_tag: assert property (@(posedge clock) disable iff (reset)
      result.status_value != '0 |-> result.kind == hsp_pkg::K_SDONE)
      else $error("status value outside status-done result");

   // literal position never runs past the version literal
   a_lit_pos: assert property (@(posedge clock) disable iff (reset)
      literal_pos_ff <= LIT_LAST)
      else $error("literal position out of range");

endmodule

@@ rtl/http_start_line_header_parser.sv @@
// top level: input register, parser core and result register
//
//   port       dir   role      contents
//   req_chan   in    sink      data_byte, at_end
//   rsp_chan   out   source    kind, data_char, status_value, header_end, cr_before
//   csr_*      in    write     response_mode
//
// One byte per cycle sustained while the result side does not stall. A byte is
// captured in the input register and parsed from there; its result is captured in
// the result register, from which it transfers. The parser state loop holds no
// register but the state itself, so every byte sees the state left by the one
// before it. Synchronous reset clears both register valids, the parser state and
// response_mode. A stalled result holds the result register; the input register then
// holds one more byte before ready drops.
module http_start_line_header_parser (
   input  logic        clock,
   input  logic        reset,
   hsp_req_if.sink     req_chan,
   hsp_rsp_if.source   rsp_chan,
   input  logic        csr_write_en,
   input  logic        csr_write_data
);

   logic                     response_mode_ff;
   logic                     in_valid_ff;
   hsp_pkg::byte_type        data_byte_ff;
   logic                     at_end_ff;
   logic                     out_valid_ff;
   hsp_pkg::rsp_payload_type out_data_ff;
   hsp_pkg::rsp_payload_type out_data_in;
   logic                     out_free;
   logic                     step_en;

   // handshake flow
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign step_en        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         response_mode_ff <= 1'b0;
      end else if (csr_write_en) begin
         response_mode_ff <= csr_write_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         data_byte_ff <= req_chan.data_byte;
         at_end_ff    <= req_chan.at_end;
      end
   end

   // parser
   hsp_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step_en),
      .response_mode (response_mode_ff),
      .data_byte     (data_byte_ff),
      .at_end        (at_end_ff),
      .result        (out_data_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.kind         = out_data_ff.kind;
   assign rsp_chan.data_char    = out_data_ff.data_char;
   assign rsp_chan.status_value = out_data_ff.status_value;
   assign rsp_chan.header_end   = out_data_ff.header_end;
   assign rsp_chan.cr_before    = out_data_ff.cr_before;

endmodule

@@ bench/http_start_line_header_parser_test.sv @@
// testbench for the http start line and header parser: scripted and random byte streams
`timescale 1ns / 100ps

module http_start_line_header_parser_test;

   localparam int CLOCK_PERIOD  = 10;
   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int MAX_REPORTS   = 10;

   localparam hsp_pkg::byte_type CH_TAB = 8'h09;
   localparam hsp_pkg::byte_type CH_LF  = 8'h0a;
   localparam hsp_pkg::byte_type CH_CR  = 8'h0d;
   localparam hsp_pkg::byte_type CH_SP  = 8'h20;
   localparam logic [39:0] VERSION_TAG = "HTTP/";

   // ways a generated message is damaged
   typedef enum int {
      FLAW_NONE,
      FLAW_EARLY_END,
      FLAW_BAD_BYTE,
      FLAW_STATUS_COUNT,
      FLAW_VALUE_CR,
      FLAW_VALUE_CTL,
      FLAW_BLANK_CR
   } flaw_type;

   typedef struct packed {
      hsp_pkg::byte_type data;
      logic              is_end;
   } stream_item_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic csr_write_data;

   hsp_req_if req_chan ();
   hsp_rsp_if rsp_chan ();

   http_start_line_header_parser u_top (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   int sender_idle_pct;
   int receiver_stall_pct;
   int mismatch_count = 0;
   int result_count = 0;
   int cycle_count = 0;

   hsp_pkg::rsp_payload_type expected_tags[$];
   stream_item_type msg_q[$];

   // parser copy kept by the bench
   logic                status_line_mode;
   hsp_pkg::phase_type  parse_phase;
   logic [2:0]          lit_idx;
   logic [1:0]          digits_seen;
   hsp_pkg::status_type status_sum;
   logic                field_started;
   logic                held_cr;

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // character classes
   function automatic bit is_ctl(input hsp_pkg::byte_type c);
      return c <= 8'd31 || c == 8'd127;
   endfunction

   function automatic bit is_ws(input hsp_pkg::byte_type c);
      return c == CH_SP || c == CH_TAB;
   endfunction

   function automatic bit is_decimal(input hsp_pkg::byte_type c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_token(input hsp_pkg::byte_type c);
      if (c >= 8'd128 || is_ctl(c)) return 1'b0;
      return !(c inside {"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/",
                         "[", "]", "?", "=", "{", "}", CH_SP, CH_TAB});
   endfunction

   function automatic void clear_parser();
      parse_phase = hsp_pkg::PH_START;
      lit_idx = '0;
      digits_seen = '0;
      status_sum = '0;
      field_started = 1'b0;
      held_cr = 1'b0;
   endfunction

   function automatic void enter_phase(input hsp_pkg::phase_type p);
      parse_phase = p;
      field_started = 1'b0;
   endfunction

   // tag one byte or end mark and advance the parser copy
   function automatic hsp_pkg::rsp_payload_type tag_byte(input hsp_pkg::byte_type c,
                                                         input logic is_end);
      hsp_pkg::rsp_payload_type r;
      hsp_pkg::kind_type k;
      r = '0;
      r.data_char = c;
      k = hsp_pkg::K_ERR;
      // an end mark aborts the message in any phase
      if (is_end) begin
         clear_parser();
         r.kind = hsp_pkg::K_ERR;
         r.data_char = '0;
         return r;
      end
      if (parse_phase == hsp_pkg::PH_START) begin
         clear_parser();
         parse_phase = status_line_mode ? hsp_pkg::PH_LIT : hsp_pkg::PH_METHOD;
      end
      // whitespace after a value's line break folds the next line into the value
      if (parse_phase == hsp_pkg::PH_VLF) begin
         if (is_ws(c)) begin
            parse_phase = hsp_pkg::PH_VSKIP;
            r.kind = hsp_pkg::K_SYN;
            return r;
         end
         r.header_end = 1'b1;
         parse_phase = hsp_pkg::PH_HLINE;
      end
      // a held reason cr closes the line only when lf follows
      if (parse_phase == hsp_pkg::PH_REASON && held_cr) begin
         held_cr = 1'b0;
         if (c == CH_LF) begin
            enter_phase(hsp_pkg::PH_HLINE);
            r.kind = hsp_pkg::K_SYN;
            return r;
         end
         r.cr_before = 1'b1;
      end
      case (parse_phase)
         hsp_pkg::PH_METHOD: begin
            if (is_token(c)) begin
               k = hsp_pkg::K_METHOD;
               field_started = 1'b1;
            end else if (c == CH_SP && field_started) begin
               k = hsp_pkg::K_SYN;
               enter_phase(hsp_pkg::PH_URI);
            end
         end
         hsp_pkg::PH_URI: begin
            if (!is_ctl(c) && c != CH_SP) begin
               k = hsp_pkg::K_URI;
               field_started = 1'b1;
            end else if (c == CH_SP && field_started) begin
               k = hsp_pkg::K_SYN;
               enter_phase(hsp_pkg::PH_LIT);
               lit_idx = '0;
            end
         end
         hsp_pkg::PH_LIT: begin
            if (lit_idx < 3'd5 && c == VERSION_TAG[39 - 8 * lit_idx -: 8]) begin
               k = hsp_pkg::K_SYN;
               lit_idx++;
               if (lit_idx == 3'd5) begin
                  enter_phase(hsp_pkg::PH_MAJOR);
                  lit_idx = '0;
               end
            end
         end
         hsp_pkg::PH_MAJOR: begin
            if (is_decimal(c)) begin
               k = hsp_pkg::K_MAJOR;
               field_started = 1'b1;
            end else if (c == "." && field_started) begin
               k = hsp_pkg::K_SYN;
               enter_phase(hsp_pkg::PH_MINOR);
            end
         end
         hsp_pkg::PH_MINOR: begin
            if (is_decimal(c)) begin
               k = hsp_pkg::K_MINOR;
               field_started = 1'b1;
            end else if (field_started && !status_line_mode && c == CH_CR) begin
               k = hsp_pkg::K_SYN;
               enter_phase(hsp_pkg::PH_REQLF);
            end else if (field_started && status_line_mode && c == CH_SP) begin
               k = hsp_pkg::K_SYN;
               enter_phase(hsp_pkg::PH_STATUS);
               digits_seen = '0;
               status_sum = '0;
            end
         end
         hsp_pkg::PH_REQLF: begin
            if (c == CH_LF) begin
               k = hsp_pkg::K_SYN;
               enter_phase(hsp_pkg::PH_HLINE);
            end
         end
         hsp_pkg::PH_STATUS: begin
            if (is_decimal(c)) begin
               if (digits_seen < 2'd3) begin
                  k = hsp_pkg::K_SDIGIT;
                  status_sum = hsp_pkg::status_type'(status_sum * 10 + (c - "0"));
                  digits_seen++;
               end
            end else if (c == CH_SP && digits_seen == 2'd3) begin
               k = hsp_pkg::K_SDONE;
               r.status_value = status_sum;
               enter_phase(hsp_pkg::PH_REASON);
            end
         end
         hsp_pkg::PH_REASON: begin
            if (c == CH_CR) begin
               k = hsp_pkg::K_SYN;
               held_cr = 1'b1;
            end else begin
               k = hsp_pkg::K_REASON;
            end
         end
         hsp_pkg::PH_HLINE: begin
            if (c == CH_CR) begin
               k = hsp_pkg::K_SYN;
               enter_phase(hsp_pkg::PH_ENDLF);
            end else if (is_token(c)) begin
               k = hsp_pkg::K_NAME;
               enter_phase(hsp_pkg::PH_HNAME);
            end
         end
         hsp_pkg::PH_ENDLF: begin
            // lf of the empty line completes the message
            if (c == CH_LF) begin
               clear_parser();
               r.kind = hsp_pkg::K_DONE;
               return r;
            end
         end
         hsp_pkg::PH_HNAME: begin
            if (c == ":") begin
               k = hsp_pkg::K_SYN;
               enter_phase(hsp_pkg::PH_HWS);
            end else if (is_token(c)) begin
               k = hsp_pkg::K_NAME;
            end
         end
         hsp_pkg::PH_HWS: begin
            if (is_ws(c)) begin
               k = hsp_pkg::K_SYN;
               enter_phase(hsp_pkg::PH_VSKIP);
            end
         end
         hsp_pkg::PH_VSKIP: begin
            if (is_ws(c)) begin
               k = hsp_pkg::K_SYN;
            end else if (c == CH_CR) begin
               k = hsp_pkg::K_SYN;
               enter_phase(hsp_pkg::PH_VCR);
            end else if (!is_ctl(c)) begin
               k = hsp_pkg::K_VALUE;
               enter_phase(hsp_pkg::PH_VALUE);
            end
         end
         hsp_pkg::PH_VALUE: begin
            if (c == CH_CR) begin
               k = hsp_pkg::K_SYN;
               enter_phase(hsp_pkg::PH_VCR);
            end else if (!is_ctl(c)) begin
               k = hsp_pkg::K_VALUE;
            end
         end
         hsp_pkg::PH_VCR: begin
            if (c == CH_LF) begin
               k = hsp_pkg::K_SYN;
               enter_phase(hsp_pkg::PH_VLF);
            end
         end
         default: ;
      endcase
      if (k == hsp_pkg::K_ERR) clear_parser();
      r.kind = k;
      return r;
   endfunction

   // message building
   function automatic void add_item(input stream_item_type item);
      msg_q.insert(msg_q.size(), item);
   endfunction

   function automatic void put(input hsp_pkg::byte_type b);
      add_item('{data: b, is_end: 1'b0});
   endfunction

   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++) put(hsp_pkg::byte_type'(s[i]));
   endfunction

   function automatic hsp_pkg::byte_type rand_token_char();
      hsp_pkg::byte_type c;
      do c = hsp_pkg::byte_type'($urandom_range(33, 126)); while (!is_token(c));
      return c;
   endfunction

   // printable or high byte, never space
   function automatic hsp_pkg::byte_type rand_text_char();
      if ($urandom_range(3) == 0) return hsp_pkg::byte_type'($urandom_range(128, 255));
      return hsp_pkg::byte_type'($urandom_range(33, 126));
   endfunction

   function automatic hsp_pkg::byte_type rand_digit();
      return hsp_pkg::byte_type'("0" + $urandom_range(9));
   endfunction

   function automatic hsp_pkg::byte_type rand_space();
      return $urandom_range(1) ? CH_SP : CH_TAB;
   endfunction

   function automatic hsp_pkg::byte_type rand_not_lf();
      hsp_pkg::byte_type c;
      c = hsp_pkg::byte_type'($urandom_range(255));
      return (c == CH_LF) ? hsp_pkg::byte_type'("y") : c;
   endfunction

   function automatic void put_version();
      int count;
      put_text("HTTP/");
      count = $urandom_range(1, 2);
      repeat (count) put(rand_digit());
      put(".");
      count = $urandom_range(1, 2);
      repeat (count) put(rand_digit());
   endfunction

   function automatic void build_message(input logic status_line, input flaw_type flaw);
      int count;
      int headers;
      int cut;
      int h;
      int k;
      hsp_pkg::byte_type c;
      hsp_pkg::byte_type prev;
      msg_q.delete();
      if (!status_line) begin
         count = $urandom_range(1, 6);
         repeat (count) put(rand_token_char());
         put(CH_SP);
         count = $urandom_range(1, 8);
         repeat (count) put(rand_text_char());
         put(CH_SP);
         put_version();
         put(CH_CR);
         put(CH_LF);
      end else begin
         put_version();
         put(CH_SP);
         count = 3;
         if (flaw == FLAW_STATUS_COUNT) count = $urandom_range(1) ? 4 : $urandom_range(0, 2);
         repeat (count) put(rand_digit());
         put(CH_SP);
         // free-form reason with stray cr bytes, but no cr lf before the real end
         prev = 8'h00;
         count = $urandom_range(0, 8);
         repeat (count) begin
            c = ($urandom_range(5) == 0) ? CH_CR : hsp_pkg::byte_type'($urandom_range(255));
            if (prev == CH_CR && c == CH_LF) c = "x";
            put(c);
            prev = c;
         end
         put(CH_CR);
         put(CH_LF);
      end
      headers = $urandom_range(0, 3);
      if ((flaw == FLAW_VALUE_CR || flaw == FLAW_VALUE_CTL) && headers == 0) headers = 1;
      for (h = 0; h < headers; h++) begin
         count = $urandom_range(1, 6);
         repeat (count) put(rand_token_char());
         put(":");
         count = $urandom_range(1, 3);
         repeat (count) put(rand_space());
         count = $urandom_range(0, 6);
         if (h == 0 && flaw == FLAW_VALUE_CTL) count = 3;
         for (k = 0; k < count; k++) begin
            if (h == 0 && flaw == FLAW_VALUE_CTL && k == 1)
               put($urandom_range(1) ? CH_TAB : ($urandom_range(1) ? 8'd127 :
                   hsp_pkg::byte_type'($urandom_range(31))));
            else if (k > 0 && $urandom_range(3) == 0)
               put(CH_SP);
            else
               put(rand_text_char());
         end
         put(CH_CR);
         if (h == 0 && flaw == FLAW_VALUE_CR) put(rand_not_lf());
         else put(CH_LF);
         // folded continuation line
         if ($urandom_range(3) == 0) begin
            count = $urandom_range(1, 2);
            repeat (count) put(rand_space());
            count = $urandom_range(0, 4);
            repeat (count) put(rand_text_char());
            put(CH_CR);
            put(CH_LF);
         end
      end
      put(CH_CR);
      if (flaw == FLAW_BLANK_CR) put(rand_not_lf());
      else put(CH_LF);
      // cut short with an end mark, or overwrite one byte
      cut = $urandom_range(msg_q.size() - 1);
      if (flaw == FLAW_EARLY_END) begin
         while (msg_q.size() > cut) void'(msg_q.pop_back());
         add_item('{data: hsp_pkg::byte_type'($urandom_range(255)), is_end: 1'b1});
      end else if (flaw == FLAW_BAD_BYTE) begin
         msg_q[cut].data = hsp_pkg::byte_type'($urandom_range(255));
      end
   endfunction

   function automatic void build_noise();
      int count;
      msg_q.delete();
      count = $urandom_range(1, 6);
      repeat (count)
         add_item('{data: hsp_pkg::byte_type'($urandom_range(255)),
                    is_end: ($urandom_range(7) == 0)});
   endfunction

   // register write while the block is idle
   task automatic write_mode(input logic mode);
      csr_write_en <= 1'b1;
      csr_write_data <= mode;
      @(posedge clock);
      csr_write_en <= 1'b0;
      status_line_mode = mode;
   endtask

   // one input transfer, with random idle cycles ahead of it
   task automatic send_item(input stream_item_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data_byte <= item.data;
      req_chan.at_end <= item.is_end;
      do @(posedge clock); while (!req_chan.ready);
      expected_tags.insert(expected_tags.size(), tag_byte(item.data, item.is_end));
   endtask

   task automatic send_stream();
      foreach (msg_q[i]) send_item(msg_q[i]);
   endtask

   // stop sending and let every result come back
   task automatic finish_phase();
      req_chan.valid <= 1'b0;
      while (expected_tags.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_request_directed();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      write_mode(1'b0);
      msg_q.delete();
      // end mark, control byte and high byte at a message start
      add_item('{data: 8'hff, is_end: 1'b1});
      put(8'h00);
      put(8'hff);
      // high byte in the uri, tab before a value, folded value, empty line
      put_text("G ");
      put(8'h80);
      put_text(" HTTP/9.0");
      put(CH_CR);
      put(CH_LF);
      put_text("A: \tb");
      put(CH_CR);
      put(CH_LF);
      put_text(" c");
      put(CH_CR);
      put(CH_LF);
      put(CH_CR);
      put(CH_LF);
      send_stream();
      finish_phase();
   endtask

   task automatic test_response_directed();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      write_mode(1'b1);
      msg_q.delete();
      // top status value and a reason cr that is not a line end
      put_text("HTTP/0.9 999 ");
      put(CH_CR);
      put_text("x");
      put(CH_CR);
      put(CH_LF);
      put(CH_CR);
      put(CH_LF);
      send_stream();
      finish_phase();
   endtask

   task automatic test_random_stream(input int idle_pct, input int stall_pct,
                                     input logic mode, input int item_target);
      int sent;
      int pick;
      sent = 0;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      write_mode(mode);
      while (sent < item_target) begin
         pick = $urandom_range(99);
         if (pick < 55)
            build_message(mode, FLAW_NONE);
         else if (pick < 85)
            build_message(mode, flaw_type'($urandom_range(FLAW_EARLY_END, FLAW_BLANK_CR)));
         else if (pick < 93)
            build_message(!mode, FLAW_NONE);
         else
            build_noise();
         sent += msg_q.size();
         send_stream();
      end
      finish_phase();
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // compare each result transfer with the oldest expected tag
   always @(posedge clock) begin
      hsp_pkg::rsp_payload_type got;
      hsp_pkg::rsp_payload_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.kind = rsp_chan.kind;
         got.data_char = rsp_chan.data_char;
         got.status_value = rsp_chan.status_value;
         got.header_end = rsp_chan.header_end;
         got.cr_before = rsp_chan.cr_before;
         if (expected_tags.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("result %0d unexpected: kind %0d char %h", result_count,
                        got.kind, got.data_char);
         end else begin
            want = expected_tags.pop_front();
            if (got.kind !== want.kind || got.data_char !== want.data_char ||
                got.status_value !== want.status_value ||
                got.header_end !== want.header_end || got.cr_before !== want.cr_before) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"result %0d: expected kind %0d char %h status %0d hend %b crb %b,",
                            " got kind %0d char %h status %0d hend %b crb %b"},
                           result_count, want.kind, want.data_char, want.status_value,
                           want.header_end, want.cr_before, got.kind, got.data_char,
                           got.status_value, got.header_end, got.cr_before);
            end
         end
         result_count++;
      end
   end

   // run time limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_write_data = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.data_byte = '0;
      req_chan.at_end = 1'b0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      status_line_mode = 1'b0;
      clear_parser();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_request_directed();
      test_response_directed();
      test_random_stream(0, 0, 1'b0, 260);
      test_random_stream(67, 0, 1'b1, 260);
      test_random_stream(0, 67, 1'b0, 260);
      test_random_stream(13, 13, 1'b1, 260);
      if (mismatch_count == 0 && expected_tags.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/hsp_pkg.sv
rtl/hsp_if.sv
rtl/hsp_core.sv
rtl/http_start_line_header_parser.sv
bench/http_start_line_header_parser_test.sv
